FILE: sv/tse_pkg.sv
// shared constants and types for the taylor series evaluator
package tse_pkg;

    localparam int ARG_FRAC      = 27;
    localparam int ARG_W         = 32;
    localparam int TERM_W        = 47;
    localparam int SUM_W         = 48;
    localparam int CNT_W         = 7;
    localparam int DSR_W         = 7;
    localparam int DIG_W         = 8;
    localparam int DIV_CELLS     = 6;
    localparam int DIV_W         = DIG_W * DIV_CELLS;
    localparam int LO_W          = 24;
    localparam int HI_W          = TERM_W - LO_W;

    localparam int MAX_TERMS_DEF = 32;
    localparam int FRAC_BITS_DEF = 24;

    localparam logic [1:0] KIND_COS = 2'd0;
    localparam logic [1:0] KIND_SIN = 2'd1;
    localparam logic [1:0] KIND_EXP = 2'd2;
    localparam logic [1:0] KIND_LN  = 2'd3;

    typedef struct packed {
        logic             valid;
        logic [DSR_W-1:0] rem;
        logic [DSR_W-1:0] dsr;
        logic [DIV_W-1:0] word;
    } div_stage_t;

endpackage

FILE: sv/tse_div_cell.sv
// one divider cell: eight restoring quotient bits per cycle
module tse_div_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  tse_pkg::div_stage_t stage_in,
    output tse_pkg::div_stage_t stage_out
);
    import tse_pkg::*;

    div_stage_t stage_reg;
    div_stage_t stage_next;

    always_comb
    begin : digit
        logic [DSR_W:0]   r;
        logic [DIG_W-1:0] q;
        r = {1'b0, stage_in.rem};
        q = '0;
        for (int i = 0; i < DIG_W; i++)
        begin
            r = {r[DSR_W-1:0], stage_in.word[DIV_W-1-i]};
            if (r >= {1'b0, stage_in.dsr})
            begin
                r = r - {1'b0, stage_in.dsr};
                q[DIG_W-1-i] = 1'b1;
            end
        end
        stage_next.valid = stage_in.valid;
        stage_next.rem   = r[DSR_W-1:0];
        stage_next.dsr   = stage_in.dsr;
        stage_next.word  = {stage_in.word[DIV_W-DIG_W-1:0], q};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
        end
        else
        begin
            stage_reg <= stage_next;
        end
    end

    assign stage_out = stage_reg;

endmodule

FILE: sv/tse_divider.sv
// term divider: a row of digit cells, remainder handed cell to cell
module tse_divider (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [tse_pkg::TERM_W-1:0]   dividend,
    input  logic [tse_pkg::DSR_W-1:0]    divisor,
    output logic                         done,
    output logic [tse_pkg::TERM_W-1:0]   quotient
);
    import tse_pkg::*;

    div_stage_t chain [DIV_CELLS+1];

    assign chain[0] = '{valid: start, rem: '0, dsr: divisor,
                        word: {{(DIV_W-TERM_W){1'b0}}, dividend}};

    for (genvar c = 0; c < DIV_CELLS; c++)
    begin : g_cell
        tse_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .stage_in  (chain[c]),
            .stage_out (chain[c+1])
        );
    end

    assign done     = chain[DIV_CELLS].valid;
    assign quotient = chain[DIV_CELLS].word[TERM_W-1:0];

endmodule

FILE: sv/taylor_series_evaluator.sv
// taylor series evaluator top level: term sequencer, multiplier, divider and sum
// each term is set by the split multiply and the six-cell divider
// one item at a time; a new item is taken while the previous result waits
// rst_n clears the sequencer and the valid flags at once
module taylor_series_evaluator #(
    parameter int MAX_TERMS = tse_pkg::MAX_TERMS_DEF,
    parameter int FRAC_BITS = tse_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         kind,
    input  logic signed [31:0] arg_value,
    input  logic [5:0]         term_count,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [47:0] series_sum,
    output logic               overflow_flag
);
    import tse_pkg::*;

    localparam int UP_SH = (FRAC_BITS >= ARG_FRAC) ? FRAC_BITS - ARG_FRAC : 0;
    localparam int DN_SH = (FRAC_BITS < ARG_FRAC) ? ARG_FRAC - FRAC_BITS : 0;
    localparam logic [TERM_W-1:0] ONE_MAG = TERM_W'(64'd1 << FRAC_BITS);
    localparam logic [TERM_W-1:0] MAG_MAX = {TERM_W{1'b1}};

    typedef enum logic [3:0] {
        ST_IDLE, ST_LOOP, ST_MUL1, ST_MUL2, ST_MUL3, ST_SCALE,
        ST_DIV_START, ST_DIV_WAIT, ST_ADD, ST_DONE
    } state_t;

    state_t                state_reg;
    logic [1:0]            kind_reg;
    logic [CNT_W-1:0]      n_reg;
    logic [CNT_W-1:0]      j_reg;
    logic                  half_reg;
    logic                  op_neg_reg;
    logic [ARG_W-1:0]      op_mag_reg;
    logic                  term_neg_reg;
    logic [TERM_W-1:0]     term_mag_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic                  ovf_reg;
    logic [LO_W+ARG_W-1:0] p_lo_reg;
    logic [HI_W+ARG_W-1:0] p_hi_reg;
    logic [DSR_W-1:0]      dsr_reg;
    logic                  out_valid_reg;
    logic signed [SUM_W-1:0] series_sum_reg;
    logic                  overflow_reg;

    logic                  div_done;
    logic [TERM_W-1:0]     div_quot;

    // input decode
    logic [CNT_W-1:0]      n_in;
    logic                  x_neg;
    logic [ARG_W-1:0]      x_mag;
    logic signed [ARG_W:0] u_val;
    logic                  u_neg;
    logic [ARG_W:0]        u_abs;
    logic [63:0]           sin_frac;
    logic [63:0]           ln_frac;

    always_comb
    begin
        n_in = (term_count == '0) ? CNT_W'(1) : {1'b0, term_count};
        if (n_in > CNT_W'(MAX_TERMS))
        begin
            n_in = CNT_W'(MAX_TERMS);
        end
        x_neg    = arg_value[ARG_W-1];
        x_mag    = x_neg ? (ARG_W'(0) - arg_value) : arg_value;
        u_val    = {arg_value[ARG_W-1], arg_value} - (33'sd1 <<< ARG_FRAC);
        u_neg    = u_val[ARG_W];
        u_abs    = u_neg ? ((ARG_W+1)'(0) - u_val) : u_val;
        sin_frac = ({32'd0, x_mag} << UP_SH) >> DN_SH;
        ln_frac  = ({32'd0, u_abs[ARG_W-1:0]} << UP_SH) >> DN_SH;
    end

    // term arithmetic
    logic [LO_W+ARG_W+HI_W-1:0] full_prod;
    logic [51:0]                mul_res;
    logic [TERM_W+CNT_W-1:0]    scale_prod;
    logic [CNT_W-1:0]           j_dec;
    logic signed [SUM_W-1:0]    term_val;
    logic signed [SUM_W:0]      sum_wide;
    logic [CNT_W:0]             div_sel;

    always_comb
    begin
        full_prod  = {p_hi_reg, {LO_W{1'b0}}} + {{HI_W{1'b0}}, p_lo_reg};
        mul_res    = full_prod[ARG_FRAC +: 52];
        j_dec      = j_reg - CNT_W'(1);
        scale_prod = term_mag_reg * j_dec;
        term_val   = term_neg_reg ? (SUM_W'(0) - {1'b0, term_mag_reg})
                                  : {1'b0, term_mag_reg};
        sum_wide   = {sum_reg[SUM_W-1], sum_reg} + {term_val[SUM_W-1], term_val};
        case (kind_reg)
            KIND_COS: div_sel = half_reg ? {j_reg, 1'b0} : {j_reg, 1'b0} - 8'd1;
            KIND_SIN: div_sel = half_reg ? {j_reg, 1'b1} : {j_reg, 1'b0};
            default:  div_sel = {1'b0, j_reg};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready && state_reg != ST_DONE)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        kind_reg <= kind;
                        n_reg    <= n_in;
                        half_reg <= 1'b0;
                        ovf_reg  <= 1'b0;
                        if (kind == KIND_LN)
                        begin
                            j_reg        <= CNT_W'(2);
                            op_neg_reg   <= u_neg;
                            op_mag_reg   <= u_abs[ARG_W-1:0];
                            term_neg_reg <= u_neg;
                            term_mag_reg <= ln_frac[TERM_W-1:0];
                            sum_reg      <= u_neg ? (SUM_W'(0) - {1'b0, ln_frac[TERM_W-1:0]})
                                                  : {1'b0, ln_frac[TERM_W-1:0]};
                        end
                        else
                        begin
                            j_reg      <= CNT_W'(1);
                            op_neg_reg <= x_neg;
                            op_mag_reg <= x_mag;
                            if (kind == KIND_SIN)
                            begin
                                term_neg_reg <= x_neg;
                                term_mag_reg <= sin_frac[TERM_W-1:0];
                                sum_reg <= x_neg ? (SUM_W'(0) - {1'b0, sin_frac[TERM_W-1:0]})
                                                 : {1'b0, sin_frac[TERM_W-1:0]};
                            end
                            else
                            begin
                                term_neg_reg <= 1'b0;
                                term_mag_reg <= ONE_MAG;
                                sum_reg      <= {1'b0, ONE_MAG};
                            end
                        end
                        state_reg <= ST_LOOP;
                    end
                end
                ST_LOOP:
                begin
                    state_reg <= (j_reg < n_reg) ? ST_MUL1 : ST_DONE;
                end
                ST_MUL1:
                begin
                    p_lo_reg  <= term_mag_reg[LO_W-1:0] * op_mag_reg;
                    state_reg <= ST_MUL2;
                end
                ST_MUL2:
                begin
                    p_hi_reg  <= term_mag_reg[TERM_W-1:LO_W] * op_mag_reg;
                    state_reg <= ST_MUL3;
                end
                ST_MUL3:
                begin
                    term_neg_reg <= term_neg_reg ^ op_neg_reg;
                    if (|mul_res[51:TERM_W])
                    begin
                        term_mag_reg <= MAG_MAX;
                        ovf_reg      <= 1'b1;
                    end
                    else
                    begin
                        term_mag_reg <= mul_res[TERM_W-1:0];
                    end
                    dsr_reg   <= div_sel[DSR_W-1:0];
                    state_reg <= (kind_reg == KIND_LN) ? ST_SCALE : ST_DIV_START;
                end
                ST_SCALE:
                begin
                    if (|scale_prod[TERM_W+CNT_W-1:TERM_W])
                    begin
                        term_mag_reg <= MAG_MAX;
                        ovf_reg      <= 1'b1;
                    end
                    else
                    begin
                        term_mag_reg <= scale_prod[TERM_W-1:0];
                    end
                    state_reg <= ST_DIV_START;
                end
                ST_DIV_START:
                begin
                    state_reg <= ST_DIV_WAIT;
                end
                ST_DIV_WAIT:
                begin
                    if (div_done)
                    begin
                        term_mag_reg <= div_quot;
                        if ((kind_reg == KIND_COS || kind_reg == KIND_SIN) && !half_reg)
                        begin
                            half_reg  <= 1'b1;
                            state_reg <= ST_MUL1;
                        end
                        else
                        begin
                            half_reg <= 1'b0;
                            if (kind_reg != KIND_EXP)
                            begin
                                term_neg_reg <= !term_neg_reg;
                            end
                            state_reg <= ST_ADD;
                        end
                    end
                end
                ST_ADD:
                begin
                    if (sum_wide[SUM_W] != sum_wide[SUM_W-1])
                    begin
                        ovf_reg <= 1'b1;
                        sum_reg <= sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                                   : {1'b0, {(SUM_W-1){1'b1}}};
                    end
                    else
                    begin
                        sum_reg <= sum_wide[SUM_W-1:0];
                    end
                    j_reg     <= j_reg + CNT_W'(1);
                    state_reg <= ST_LOOP;
                end
                ST_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg  <= 1'b1;
                        series_sum_reg <= sum_reg;
                        overflow_reg   <= ovf_reg;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    tse_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == ST_DIV_START),
        .dividend (term_mag_reg),
        .divisor  (dsr_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign in_ready      = (state_reg == ST_IDLE);
    assign out_valid     = out_valid_reg;
    assign series_sum    = series_sum_reg;
    assign overflow_flag = overflow_reg;

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_LOOP))
        else $error("accepted item did not start the sequencer");

    a_div_only_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV_WAIT))
        else $error("divider result arrived outside the wait state");

    a_term_index_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOOP) |-> ({1'b0, j_reg} <= {1'b0, n_reg} + 8'd1))
        else $error("term index ran past the term count");

    a_done_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && (!out_valid_reg || out_ready)) |=> out_valid_reg)
        else $error("finished item was not presented");

endmodule
